[hdl/newton_divided_difference_coeffs_assert.svh]
// assertion macros for the divided-difference coefficient block
`ifndef NEWTON_DIVIDED_DIFFERENCE_COEFFS_ASSERT_SVH
`define NEWTON_DIVIDED_DIFFERENCE_COEFFS_ASSERT_SVH
`ifndef SYNTHESIS
`define NDD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NDD_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NDD_ASSERT(label, clk, rst_n, prop, msg)
`define NDD_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[hdl/ndd_pkg.sv]
// package: types and constants of the divided-difference block
`timescale 1ns / 1ps
package ndd_pkg;
  localparam int unsigned QBits = 16;
  localparam int unsigned NumDeriv = 3;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrTooMany  = 2'd1,
    ErrDerivOrd = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    StIdle, StStartCol, StRdA, StRdB, StEval, StDivWait, StWrite, StNextCol,
    StEmitRd, StEmitWait, StEmitOut, StErrOut
  } state_e;

  // word passed from front to back through the queue
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic signed [31:0] d3;
    logic               last;
  } point_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

[hdl/ndd_queue.sv]
// two-entry queue between front and back
`timescale 1ns / 1ps
module ndd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  ndd_pkg::point_t word_i,
  output logic            valid_o,
  input  logic            stall_i,
  output ndd_pkg::point_t word_o
);
  ndd_pkg::point_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push, pop;

  assign stall_o = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign push    = valid_i && !stall_o;
  assign pop     = valid_o && !stall_i;
  assign word_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= word_i;
  end
endmodule

[hdl/ndd_divider.sv]
// iterative signed 64-bit divider, one quotient bit a cycle
`timescale 1ns / 1ps
`include "newton_divided_difference_coeffs_assert.svh"
module ndd_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ndd_pkg::div_req_t req_i,
  output ndd_pkg::div_rsp_t rsp_o
);
  logic [63:0] rem_q, quo_q, den_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q, neg_q;
  logic [64:0] trial;
  logic [63:0] rem_sh;

  assign rem_sh = {rem_q[62:0], quo_q[63]};
  assign trial  = {1'b0, rem_sh} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= '0;
      quo_q <= req_i.num[63] ? 64'(-req_i.num) : req_i.num;
      den_q <= req_i.den[63] ? 64'(-req_i.den) : req_i.den;
      neg_q <= req_i.num[63] ^ req_i.den[63];
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  `NDD_ASSERT(a_done_after_busy, clk_i, rst_ni, rsp_o.done |-> $past(busy_q), "done without busy")
  `NDD_ASSERT(a_not_both, clk_i, rst_ni, !(busy_q && done_q), "busy and done together")
  `NDD_ASSERT(a_cnt_range, clk_i, rst_ni, !busy_q || cnt_q < 7'd64, "count overrun")
endmodule

[hdl/ndd_back.sv]
// back end: point store, table sweep and coefficient output
`timescale 1ns / 1ps
`include "newton_divided_difference_coeffs_assert.svh"
module ndd_back #(
  parameter int unsigned MaxPoints = 16,
  parameter int unsigned MaxDerivOrder = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  ndd_pkg::point_t    word_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] coefficient_o,
  output logic [3:0]         term_index_o,
  output logic               last_term_o,
  output logic [1:0]         error_code_o
);
  localparam int unsigned IW = $clog2(MaxPoints);
  localparam int unsigned CW = $clog2(MaxPoints + 1);
  localparam int unsigned MaxOrd = (MaxDerivOrder < 3) ? MaxDerivOrder : 3;

  logic signed [31:0] x_mem [MaxPoints];
  logic signed [31:0] d_mem [MaxPoints];
  logic [95:0]        dv_mem [MaxPoints];
  logic signed [31:0] coef_mem [MaxPoints];

  ndd_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, i_q, i_d, j_q, j_d;
  logic [1:0]    err_q, err_d;
  logic          ovf_q, ovf_d;

  logic signed [31:0] xa_q, xb_q, da_q, db_q, coef_rd_q;
  logic [95:0]        dv_q;
  logic signed [31:0] val_q, val_d;
  logic signed [31:0] out_coef_q, out_coef_d;
  logic [3:0]         out_idx_q, out_idx_d;
  logic               out_last_q, out_last_d, out_v_q, out_v_d;
  logic [1:0]         out_err_q, out_err_d;
  ndd_pkg::div_req_t  dreq;
  ndd_pkg::div_rsp_t  drsp;
  logic               accept, wr_d_en, wr_c_en;
  logic signed [31:0] dsel, dq;
  logic [31:0]        dmag, d6;
  logic [63:0]        dprod;
  logic [CW-1:0]      ij;
  logic signed [31:0] d0_q;

  assign accept = valid_i && !stall_o;
  assign stall_o = state_q != ndd_pkg::StIdle;
  assign ij = i_q + j_q;

  always_comb begin
    unique case (j_q[1:0])
      2'd1: dsel = dv_q[95:64];
      2'd2: dsel = dv_q[63:32];
      default: dsel = dv_q[31:0];
    endcase
  end

  // divide by j!: 1, 2 (shift rounding toward zero), 6 by reciprocal multiply
  assign dmag  = dsel[31] ? 32'(-dsel) : dsel;
  assign dprod = {32'd0, dmag} * {32'd0, 32'hAAAA_AAAB};
  assign d6    = {2'b00, dprod[63:34]};

  always_comb begin
    dq = dsel;
    if (j_q == CW'(2)) dq = $signed(dsel + 32'(dsel[31])) >>> 1;
    else if (j_q == CW'(3)) dq = dsel[31] ? -$signed(d6) : $signed(d6);
  end

  ndd_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; n_d = n_q; i_d = i_q; j_d = j_q;
    err_d = err_q; ovf_d = ovf_q; val_d = val_q;
    out_coef_d = out_coef_q; out_idx_d = out_idx_q; out_last_d = out_last_q;
    out_err_d = out_err_q; out_v_d = out_v_q;
    dreq = '0; wr_d_en = 1'b0; wr_c_en = 1'b0;
    if (out_v_q && !stall_i) out_v_d = 1'b0;
    unique case (state_q)
      ndd_pkg::StIdle: begin
        if (accept) begin
          if (cnt_q < CW'(MaxPoints)) cnt_d = cnt_q + CW'(1);
          else ovf_d = 1'b1;
          if (word_i.last) begin
            n_d   = (cnt_q < CW'(MaxPoints)) ? cnt_q + CW'(1) : cnt_q;
            err_d = (ovf_q || !(cnt_q < CW'(MaxPoints))) ? ndd_pkg::ErrTooMany
                                                         : ndd_pkg::ErrNone;
            j_d = CW'(1);
            state_d = ndd_pkg::StStartCol;
          end
        end
      end
      ndd_pkg::StStartCol: begin
        i_d = '0;
        state_d = (j_q < n_q) ? ndd_pkg::StRdA : ndd_pkg::StEmitRd;
      end
      ndd_pkg::StRdA: state_d = ndd_pkg::StRdB;
      ndd_pkg::StRdB: state_d = ndd_pkg::StEval;
      ndd_pkg::StEval: begin
        if (xa_q == xb_q) begin
          if (j_q > CW'(MaxOrd)) begin
            if (err_q == ndd_pkg::ErrNone) err_d = ndd_pkg::ErrDerivOrd;
            val_d = '0;
            state_d = ndd_pkg::StWrite;
          end else begin
            val_d = dq;
            state_d = ndd_pkg::StWrite;
          end
        end else begin
          dreq.start = 1'b1;
          dreq.num = (64'(db_q) - 64'(da_q)) <<< ndd_pkg::QBits;
          dreq.den = 64'(xb_q) - 64'(xa_q);
          state_d = ndd_pkg::StDivWait;
        end
      end
      ndd_pkg::StDivWait: begin
        if (drsp.done) begin
          val_d = ndd_pkg::sat32(drsp.quo);
          state_d = ndd_pkg::StWrite;
        end
      end
      ndd_pkg::StWrite: begin
        wr_d_en = 1'b1;
        i_d = i_q + CW'(1);
        state_d = (ij + CW'(1) < n_q) ? ndd_pkg::StRdA : ndd_pkg::StNextCol;
      end
      ndd_pkg::StNextCol: begin
        wr_c_en = 1'b1;
        j_d = j_q + CW'(1);
        state_d = ndd_pkg::StStartCol;
      end
      ndd_pkg::StEmitRd: begin
        i_d = '0;
        state_d = (err_q != ndd_pkg::ErrNone) ? ndd_pkg::StErrOut
                                              : ndd_pkg::StEmitWait;
      end
      ndd_pkg::StEmitWait: state_d = ndd_pkg::StEmitOut;
      ndd_pkg::StEmitOut: begin
        if (!out_v_d) begin
          out_v_d = 1'b1;
          out_coef_d = (i_q == '0) ? d0_q : coef_rd_q;
          out_idx_d = 4'(i_q);
          out_last_d = i_q + CW'(1) == n_q;
          out_err_d = ndd_pkg::ErrNone;
          i_d = i_q + CW'(1);
          if (i_q + CW'(1) == n_q) begin
            cnt_d = '0; ovf_d = 1'b0; state_d = ndd_pkg::StIdle;
          end else state_d = ndd_pkg::StEmitWait;
        end
      end
      ndd_pkg::StErrOut: begin
        if (!out_v_d) begin
          out_v_d = 1'b1; out_coef_d = '0; out_idx_d = '0; out_last_d = 1'b1;
          out_err_d = err_q; cnt_d = '0; ovf_d = 1'b0;
          state_d = ndd_pkg::StIdle;
        end
      end
      default: state_d = ndd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ndd_pkg::StIdle;
      cnt_q <= '0; ovf_q <= 1'b0; out_v_q <= 1'b0; err_q <= '0;
      n_q <= '0; i_q <= '0; j_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d; out_v_q <= out_v_d;
      err_q <= err_d; n_q <= n_d; i_q <= i_d; j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    out_coef_q <= out_coef_d; out_idx_q <= out_idx_d;
    out_last_q <= out_last_d; out_err_q <= out_err_d;
    if (accept && cnt_q < CW'(MaxPoints)) begin
      x_mem[cnt_q[IW-1:0]]  <= word_i.x;
      d_mem[cnt_q[IW-1:0]]  <= word_i.y;
      dv_mem[cnt_q[IW-1:0]] <= {word_i.d1, word_i.d2, word_i.d3};
      if (cnt_q == '0) d0_q <= word_i.y;
    end
    if (state_q == ndd_pkg::StRdA) begin
      xa_q <= x_mem[i_q[IW-1:0]];
      da_q <= d_mem[i_q[IW-1:0]];
      dv_q <= dv_mem[i_q[IW-1:0]];
    end
    if (state_q == ndd_pkg::StRdB) begin
      xb_q <= x_mem[ij[IW-1:0]];
      db_q <= d_mem[IW'(i_q + CW'(1))];
    end
    if (wr_d_en) d_mem[i_q[IW-1:0]] <= val_q;
    if (wr_c_en) coef_mem[j_q[IW-1:0]] <= d_mem[0];
    if (state_q == ndd_pkg::StEmitWait) coef_rd_q <= coef_mem[i_q[IW-1:0]];
  end

  assign valid_o = out_v_q;
  assign coefficient_o = out_coef_q;
  assign term_index_o = out_idx_q;
  assign last_term_o = out_last_q;
  assign error_code_o = out_err_q;

  `NDD_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= CW'(MaxPoints), "point count overrun")
  `NDD_ASSERT(a_ok_last, clk_i, rst_ni, (valid_o && error_code_o != ndd_pkg::ErrNone) |-> last_term_o, "error word not last")
  `NDD_ASSERT(a_idle_busy, clk_i, rst_ni, drsp.busy |-> state_q == ndd_pkg::StDivWait, "divider busy outside wait")
endmodule

[hdl/newton_divided_difference_coeffs.sv]
// top level: Newton / Hermite divided-difference coefficient generator
// points enter one word per cycle, unless stalled, on the input channel
// (valid_i, stall_o), each with x, y, three derivatives in signed Q16.16;
// last_point_i ends the set. a two-word queue decouples the input from the
// compute back end. the back end stores points, then sweeps the table column
// by column, reading two entries per step; each difference quotient of
// distinct abscissae is formed on one shared iterative divider, and a
// repeated abscissa takes its derivative divided by j! instead.
// coefficients leave on the output channel (valid_o, stall_i), order 0
// first, last_term_o on the final one; on error a single word with zero
// coefficient and the error code is sent instead.
// while the receiver stalls, the output word holds and the next coefficient waits.
// loading continues into the queue, up to two words, while the back end is busy.
// reset clears the counters and the pending error; point storage is
// written before it is read and needs no clearing.
`timescale 1ns / 1ps
module newton_divided_difference_coeffs #(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned MAX_DERIV_ORDER = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] x_value_i,
  input  logic signed [31:0] y_value_i,
  input  logic signed [31:0] first_derivative_i,
  input  logic signed [31:0] second_derivative_i,
  input  logic signed [31:0] third_derivative_i,
  input  logic               last_point_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] coefficient_o,
  output logic [3:0]         term_index_o,
  output logic               last_term_o,
  output logic [1:0]         error_code_o
);
  ndd_pkg::point_t in_word, q_word;
  logic q_valid, q_stall;

  assign in_word = '{x: x_value_i, y: y_value_i, d1: first_derivative_i,
                     d2: second_derivative_i, d3: third_derivative_i,
                     last: last_point_i};

  ndd_queue u_queue (
    .clk_i, .rst_ni, .valid_i, .stall_o, .word_i(in_word),
    .valid_o(q_valid), .stall_i(q_stall), .word_o(q_word)
  );

  ndd_back #(.MaxPoints(MAX_POINTS), .MaxDerivOrder(MAX_DERIV_ORDER)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .stall_o(q_stall), .word_i(q_word),
    .valid_o, .stall_i, .coefficient_o, .term_index_o, .last_term_o,
    .error_code_o
  );
endmodule

[tb/sv/newton_divided_difference_coeffs_test.sv]
// testbench: Newton / Hermite divided-difference coefficient block against an inline predictor
`timescale 1ns / 1ps
module newton_divided_difference_coeffs_test;

  typedef struct {
    logic signed [31:0] coef;
    logic [3:0]         idx;
    logic               last;
    logic [1:0]         err;
  } coef_word_t;

  typedef struct {
    ndd_pkg::point_t    pt;
    bit                 typed;
    logic signed [31:0] t_coef;
    ndd_pkg::err_e      t_err;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic signed [31:0] x_value_i = '0;
  logic signed [31:0] y_value_i = '0;
  logic signed [31:0] first_derivative_i = '0;
  logic signed [31:0] second_derivative_i = '0;
  logic signed [31:0] third_derivative_i = '0;
  logic last_point_i = 1'b0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic signed [31:0] coefficient_o;
  logic [3:0] term_index_o;
  logic last_term_o;
  logic [1:0] error_code_o;

  newton_divided_difference_coeffs u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic signed [63:0] x_held[16];
  logic signed [63:0] table_col[16];
  logic signed [63:0] deriv_held[16][3];
  int   held_count = 0;
  ndd_pkg::err_e pending_err = ndd_pkg::ErrNone;

  coef_word_t coefs_due[$];
  coef_word_t fresh[$];
  int mismatches = 0;
  int items_sent = 0;
  int sets_sent = 0;
  int words_seen = 0;
  int error_words = 0;
  int burst_left = 0;

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void absorb_point(input ndd_pkg::point_t p);
    logic signed [63:0] v, num, den, fac;
    logic signed [63:0] c[16];
    coef_word_t w;
    ndd_pkg::err_e e;
    int n;
    fresh.delete();
    if (held_count < 16) begin
      x_held[held_count] = p.x;
      table_col[held_count] = p.y;
      deriv_held[held_count][0] = p.d1;
      deriv_held[held_count][1] = p.d2;
      deriv_held[held_count][2] = p.d3;
      held_count++;
    end else begin
      pending_err = ndd_pkg::ErrTooMany;
    end
    if (!p.last) return;
    n = held_count;
    e = pending_err;
    c[0] = table_col[0];
    for (int j = 1; j < n; j++) begin
      for (int i = 0; i + j < n; i++) begin
        if (x_held[i + j] == x_held[i]) begin
          if (j > 3) begin
            if (e == ndd_pkg::ErrNone) e = ndd_pkg::ErrDerivOrd;
            v = 0;
          end else begin
            fac = (j == 3) ? 6 : (j == 2) ? 2 : 1;
            v = deriv_held[i][j - 1] / fac;
          end
        end else begin
          num = table_col[i + 1] - table_col[i];
          den = x_held[i + j] - x_held[i];
          v = (num * 64'sd65536) / den;
        end
        table_col[i] = clip32(v);
      end
      c[j] = table_col[0];
    end
    held_count = 0;
    pending_err = ndd_pkg::ErrNone;
    if (e != ndd_pkg::ErrNone) begin
      w = '{coef: 0, idx: 0, last: 1'b1, err: e};
      fresh.push_back(w);
    end else begin
      for (int i = 0; i < n; i++) begin
        w = '{coef: c[i][31:0], idx: i[3:0], last: (i == n - 1), err: ndd_pkg::ErrNone};
        fresh.push_back(w);
      end
    end
  endfunction

  // drive one word at the falling edge, hold until taken, then idle per burst
  task automatic send_word(input stim_row_t r);
    coef_word_t w;
    @(negedge clk_i);
    if (burst_left == 0) begin
      valid_i = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    x_value_i = r.pt.x;
    y_value_i = r.pt.y;
    first_derivative_i = r.pt.d1;
    second_derivative_i = r.pt.d2;
    third_derivative_i = r.pt.d3;
    last_point_i = r.pt.last;
    valid_i = 1'b1;
    do @(posedge clk_i); while (stall_o);
    burst_left--;
    items_sent++;
    absorb_point(r.pt);
    if (r.typed && r.pt.last) begin
      w = '{coef: r.t_coef, idx: 0, last: 1'b1, err: r.t_err};
      coefs_due.push_back(w);
    end else begin
      foreach (fresh[k]) coefs_due.push_back(fresh[k]);
    end
  endtask

  task automatic idle_until_drained();
    @(negedge clk_i);
    valid_i = 1'b0;
    while (coefs_due.size() != 0) @(negedge clk_i);
  endtask

  function automatic stim_row_t mk(input logic signed [31:0] x, y, d1, d2, d3,
                                   input logic last);
    stim_row_t r;
    r.pt = '{x: x, y: y, d1: d1, d2: d2, d3: d3, last: last};
    r.typed = 1'b0;
    r.t_coef = '0;
    r.t_err = ndd_pkg::ErrNone;
    return r;
  endfunction

  function automatic stim_row_t mk_typed(input stim_row_t r, input logic signed [31:0] c,
                                         input ndd_pkg::err_e e);
    r.typed = 1'b1;
    r.t_coef = c;
    r.t_err = e;
    return r;
  endfunction

  function automatic logic signed [31:0] rnd32();
    return $urandom;
  endfunction

  // receiver: stall in runs, sometimes long clean stretches
  int stall_run = 0;
  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, 20);
      stall_i <= ($urandom_range(0, 2) == 0);
    end else begin
      stall_run--;
    end
  end

  always @(posedge clk_i) begin
    coef_word_t w;
    if (rst_ni && valid_o && !stall_i) begin
      words_seen++;
      if (error_code_o != ndd_pkg::ErrNone) error_words++;
      if (coefs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: coef %h idx %0d last %b err %0d",
                   coefficient_o, term_index_o, last_term_o, error_code_o);
      end else begin
        w = coefs_due.pop_front();
        if (coefficient_o !== w.coef || term_index_o !== w.idx ||
            last_term_o !== w.last || error_code_o !== w.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp coef %h idx %0d last %b err %0d, got %h %0d %b %0d",
                     w.coef, w.idx, w.last, w.err,
                     coefficient_o, term_index_o, last_term_o, error_code_o);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("newton_divided_difference_coeffs verification failed");
    $finish;
  end

  initial begin
    stim_row_t tbl[$];
    stim_row_t r;
    int kind, n, grp;
    logic signed [31:0] xb, xs;
    localparam logic signed [31:0] One = 32'sh0001_0000;
    localparam logic signed [31:0] Mx = 32'sh7fff_ffff;
    localparam logic signed [31:0] Mn = 32'sh8000_0000;

    tbl.push_back(mk_typed(mk(Mn, Mx, 0, 0, 0, 1), Mx, ndd_pkg::ErrNone));
    tbl.push_back(mk_typed(mk(Mx, Mn, Mx, Mn, Mx, 1), Mn, ndd_pkg::ErrNone));
    tbl.push_back(mk(0, 0, 0, 0, 0, 0));
    tbl.push_back(mk(One, One, 0, 0, 0, 1));
    tbl.push_back(mk(Mn, Mx, 0, 0, 0, 0));
    tbl.push_back(mk(Mx, Mn, 0, 0, 0, 1));
    for (int k = 0; k < 4; k++)
      tbl.push_back(mk(2 * One, 4 * One, 4 * One, 2 * One, 0, k == 3));
    for (int k = 0; k < 4; k++)
      tbl.push_back(mk(-One, Mx, Mx, Mn, Mx, k == 3));
    // repeated abscissa five times needs a fourth derivative
    for (int k = 0; k < 5; k++)
      tbl.push_back(mk(3 * One, One, One, One, One, 0));
    tbl[tbl.size() - 1].pt.last = 1'b1;
    tbl[tbl.size() - 1] = mk_typed(tbl[tbl.size() - 1], 0, ndd_pkg::ErrDerivOrd);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (tbl[k]) begin
      send_word(tbl[k]);
      if (tbl[k].pt.last) sets_sent++;
    end
    idle_until_drained();

    while (items_sent < 380) begin
      if (sets_sent == 40) idle_until_drained();
      kind = $urandom_range(0, 99);
      xb = $signed($urandom_range(0, 64)) * One - 32 * One;
      xs = $urandom_range(1, 3) * 32'sh0000_4000;
      tbl.delete();
      if (kind < 55) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          tbl.push_back(mk(xb + $signed($urandom_range(0, 3)) * xs,
                           $signed($urandom_range(0, 1 << 20)) - (1 << 19),
                           $signed($urandom_range(0, 1 << 20)) - (1 << 19),
                           $signed($urandom_range(0, 1 << 20)) - (1 << 19),
                           $signed($urandom_range(0, 1 << 20)) - (1 << 19), 0));
      end else if (kind < 78) begin
        n = $urandom_range(1, 3);
        for (int g = 0; g < n; g++) begin
          grp = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 4);
          for (int k = 0; k < grp; k++)
            tbl.push_back(mk(xb + g * xs, rnd32() >>> 8, rnd32() >>> 8,
                             rnd32() >>> 8, rnd32() >>> 8, 0));
        end
      end else if (kind < 90) begin
        n = $urandom_range(2, 5);
        for (int k = 0; k < n; k++)
          tbl.push_back(mk(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), 0));
      end else if (kind < 95) begin
        for (int k = 0; k < 16; k++)
          tbl.push_back(mk(xb + k * xs, rnd32() >>> 12, rnd32() >>> 12,
                           rnd32() >>> 12, rnd32() >>> 12, 0));
      end else begin
        n = $urandom_range(17, 19);
        for (int k = 0; k < n; k++)
          tbl.push_back(mk(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), 0));
      end
      tbl[tbl.size() - 1].pt.last = 1'b1;
      foreach (tbl[k]) send_word(tbl[k]);
      sets_sent++;
    end

    idle_until_drained();
    repeat (200) @(posedge clk_i);

    $display("%0d points in %0d sets, %0d coefficient words checked (%0d error words)",
             items_sent, sets_sent, words_seen, error_words);
    if (mismatches == 0 && coefs_due.size() == 0) begin
      $display("newton_divided_difference_coeffs verification clean");
    end else begin
      $display("%0d mismatches, %0d words outstanding", mismatches, coefs_due.size());
      $display("newton_divided_difference_coeffs verification failed");
    end
    $finish;
  end
endmodule
